// ===== sv/lin_master_frame_engine_assert.svh =====
// ----------------------------------------------------------------------------
// LIN master frame engine assertion macros
// Shared concurrent assertion forms used by the frame engine RTL.
// ----------------------------------------------------------------------------
`ifndef LIN_MASTER_FRAME_ENGINE_ASSERT_SVH
`define LIN_MASTER_FRAME_ENGINE_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define LMFE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: label");

// Same-cycle implication.
`define LMFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define LMFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define LMFE_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LMFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LMFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/lmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine package
// Action and result codes, item and result types, PID and checksum helpers.
// ----------------------------------------------------------------------------
package lmfe_pkg;

    // Action codes of an input item.
    localparam logic [2:0] ACT_START_SEND = 3'd0;
    localparam logic [2:0] ACT_START_READ = 3'd1;
    localparam logic [2:0] ACT_DATA_BYTE  = 3'd2;
    localparam logic [2:0] ACT_RECV_BYTE  = 3'd3;
    localparam logic [2:0] ACT_TICK       = 3'd4;

    // Kind codes of a result.
    localparam logic [1:0] KIND_BREAK     = 2'd0;
    localparam logic [1:0] KIND_TX_BYTE   = 2'd1;
    localparam logic [1:0] KIND_RX_BYTE   = 2'd2;
    localparam logic [1:0] KIND_READ_DONE = 2'd3;

    localparam logic [7:0]  SYNC_BYTE      = 8'h55;
    localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [15:0] TICK_MAX       = 16'hFFFF;
    localparam int          MAX_RESULTS    = 4;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] length;
        logic [5:0] frame_id;
        logic [2:0] action;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       checksum_ok;
        logic       last;
    } t_result;

    // All results caused by one item, slot 0 first.
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [2:0]                count;
    } t_batch;

    // Protected identifier: ID with parity bits P0 in bit 6 and P1 in bit 7.
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // Enhanced checksum accumulate: a carry out of the byte wraps back in.
    function automatic logic [7:0] add_sum(input logic [7:0] sum, input logic [7:0] data);
        logic [8:0] s;
        s = {1'b0, sum} + {1'b0, data};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

    function automatic t_result mk_result(input logic [1:0] kind, input logic [7:0] value,
                                          input logic ok, input logic last);
        t_result r;
        r.kind        = kind;
        r.byte_value  = value;
        r.checksum_ok = ok;
        r.last        = last;
        return r;
    endfunction

endpackage

// ===== sv/lmfe_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// LIN master frame controller
// Holds the frame state and turns one registered item into its results.
// ----------------------------------------------------------------------------
module lmfe_frame_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,        // consume i_item this cycle
    input  lmfe_pkg::t_item  i_item,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    output lmfe_pkg::t_batch o_batch
);
    import lmfe_pkg::*;

    typedef enum logic [1:0] {MODE_IDLE, MODE_SEND, MODE_READ} t_mode;

    t_mode       r_mode,     n_mode;
    logic [7:0]  r_pid,      n_pid;
    logic [7:0]  r_sum,      n_sum;
    logic [3:0]  r_count,    n_count;
    logic [3:0]  r_len,      n_len;
    logic [15:0] r_tick,     n_tick;
    logic [15:0] r_timeout;

    logic [3:0]  len_clamped;
    logic [7:0]  pid;
    logic [7:0]  sum_next;
    logic [3:0]  count_inc;
    logic [15:0] tick_inc;
    logic        send_empty;

    // Shared pieces of the next-state logic.
    always_comb begin
        len_clamped = (i_item.length > MAX_DATA_BYTES) ? MAX_DATA_BYTES : i_item.length;
        pid         = protect_id(i_item.frame_id);
        sum_next    = add_sum(r_sum, i_item.data_byte);
        count_inc   = r_count + 4'd1;
        tick_inc    = (r_tick != TICK_MAX) ? (r_tick + 16'd1) : r_tick;
        send_empty  = (i_item.action == ACT_START_SEND) && (len_clamped == 4'd0);
    end

    // Results and next state for the current item.
    always_comb begin
        n_mode  = r_mode;
        n_pid   = r_pid;
        n_sum   = r_sum;
        n_count = r_count;
        n_len   = r_len;
        n_tick  = r_tick;
        o_batch = '0;
        unique case (i_item.action)
            ACT_START_SEND, ACT_START_READ: begin
                n_pid   = pid;
                n_sum   = pid;
                n_count = 4'd0;
                n_len   = len_clamped;
                n_tick  = 16'd0;
                o_batch.res[0] = mk_result(KIND_BREAK, 8'd0, 1'b0, 1'b0);
                o_batch.res[1] = mk_result(KIND_TX_BYTE, SYNC_BYTE, 1'b0, 1'b0);
                o_batch.res[2] = mk_result(KIND_TX_BYTE, pid, 1'b0, !send_empty);
                if (i_item.action == ACT_START_READ) begin
                    n_mode        = MODE_READ;
                    o_batch.count = 3'd3;
                end else if (send_empty) begin
                    // Checksum of an empty frame is the inverted PID.
                    n_mode         = MODE_IDLE;
                    o_batch.res[3] = mk_result(KIND_TX_BYTE, ~pid, 1'b0, 1'b1);
                    o_batch.count  = 3'd4;
                end else begin
                    n_mode        = MODE_SEND;
                    o_batch.count = 3'd3;
                end
            end
            ACT_DATA_BYTE: begin
                if (r_mode == MODE_SEND) begin
                    n_sum   = sum_next;
                    n_count = count_inc;
                    if (count_inc >= r_len) begin
                        n_mode         = MODE_IDLE;
                        o_batch.res[0] = mk_result(KIND_TX_BYTE, i_item.data_byte, 1'b0, 1'b0);
                        o_batch.res[1] = mk_result(KIND_TX_BYTE, ~sum_next, 1'b0, 1'b1);
                        o_batch.count  = 3'd2;
                    end else begin
                        o_batch.res[0] = mk_result(KIND_TX_BYTE, i_item.data_byte, 1'b0, 1'b1);
                        o_batch.count  = 3'd1;
                    end
                end
            end
            ACT_RECV_BYTE: begin
                if (r_mode == MODE_READ) begin
                    if (r_count < r_len) begin
                        n_sum          = sum_next;
                        n_count        = count_inc;
                        o_batch.res[0] = mk_result(KIND_RX_BYTE, i_item.data_byte, 1'b0, 1'b1);
                        o_batch.count  = 3'd1;
                    end else begin
                        // This byte is the checksum.
                        n_mode         = MODE_IDLE;
                        o_batch.res[0] = mk_result(KIND_READ_DONE, 8'd0,
                                                   i_item.data_byte == ~r_sum, 1'b1);
                        o_batch.count  = 3'd1;
                    end
                end
            end
            ACT_TICK: begin
                if (r_mode == MODE_READ) begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_timeout) begin
                        n_mode         = MODE_IDLE;
                        o_batch.res[0] = mk_result(KIND_READ_DONE, 8'd0, 1'b0, 1'b1);
                        o_batch.count  = 3'd1;
                    end
                end
            end
            default: begin
                // Undefined action codes are dropped.
            end
        endcase
    end

    // Frame state and the timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_pid     <= 8'd0;
            r_sum     <= 8'd0;
            r_count   <= 4'd0;
            r_len     <= 4'd0;
            r_tick    <= 16'd0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            if (i_go) begin
                r_mode  <= n_mode;
                r_pid   <= n_pid;
                r_sum   <= n_sum;
                r_count <= n_count;
                r_len   <= n_len;
                r_tick  <= n_tick;
            end
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== sv/lin_master_frame_engine.sv =====
// ----------------------------------------------------------------------------
// LIN master frame engine
// Header, data and enhanced checksum sequencing for a LIN master.
// ----------------------------------------------------------------------------
// An item is registered on input, decoded combinationally, and its results
// (none to four) are loaded into a four-entry result buffer that feeds the
// master stream one transfer per cycle while m_axis_tready is high. The single
// output stream sets the rate. The next item is decoded in the cycle the
// buffer hands over its last result, so items follow without gaps.
// timeout_ticks is written through i_cfg_we / i_cfg_wdata (reset 100).
`include "lin_master_frame_engine_assert.svh"

module lin_master_frame_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // timeout_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,     // action[2:0], frame_id[8:3], length[12:9],
                                          // data_byte[20:13], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // byte_value[7:0], checksum_ok[8], zero fill
    output logic [1:0]  m_axis_tuser,     // kind[1:0]
    output logic        m_axis_tlast
);
    import lmfe_pkg::*;

    logic                        r_in_vld;
    t_item                       r_in;
    t_result [MAX_RESULTS-1:0]   r_res;
    logic [2:0]                  r_cnt;
    t_batch                      batch;
    logic                        pop;
    logic                        go;

    // Output transfer and hand-over of the decoded item to the buffer.
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign go            = r_in_vld && ((r_cnt == 3'd0) || ((r_cnt == 3'd1) && pop));
    assign s_axis_tready = !r_in_vld || go;

    lmfe_frame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_batch     (batch)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= t_item'(s_axis_tdata[20:0]);
        end
    end

    // Result buffer: entry 0 is on the bus, a transfer shifts the rest down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (go) begin
            r_cnt <= batch.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_res <= batch.res;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

    // Master stream outputs.
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = {7'd0, r_res[0].checksum_ok, r_res[0].byte_value};
    assign m_axis_tuser  = r_res[0].kind;
    assign m_axis_tlast  = r_res[0].last;

    // Checks on the buffer bookkeeping.
    `LMFE_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'd4)
    `LMFE_ASSERT_IMPLY(a_last_on_final, i_clk, i_rst_n, r_cnt == 3'd1, m_axis_tlast)
    `LMFE_ASSERT_IMPLY(a_no_early_last, i_clk, i_rst_n, r_cnt > 3'd1, !m_axis_tlast)
    `LMFE_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_in_vld && !go, r_in_vld && $stable(r_in))

endmodule

// ===== bench/lin_master_frame_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN master frame engine testbench
// Drives start, data, receive and tick items into the frame engine and checks
// every result transfer against a cycle-free model of the LIN header, data and
// enhanced checksum sequencing, under random idling on both stream sides.
// ----------------------------------------------------------------------------
module lin_master_frame_engine_tb;
    import lmfe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {LINK_IDLE, LINK_SEND, LINK_READ} t_link_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // action[2:0], frame_id[8:3], length[12:9],
                                       // data_byte[20:13], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // byte_value[7:0], checksum_ok[8], zero fill
    logic [1:0]  m_axis_tuser;         // kind[1:0]
    logic        m_axis_tlast;

    // Model state of the frame engine.
    t_link_mode  link_mode    = LINK_IDLE;
    logic [7:0]  link_pid     = '0;
    logic [7:0]  link_sum     = '0;
    logic [3:0]  link_count   = '0;
    logic [3:0]  link_len     = '0;
    logic [15:0] link_ticks   = '0;
    logic [15:0] link_timeout = TIMEOUT_RESET;

    t_item   pending_items[$];
    t_result expected_results[$];

    bit item_taken = 1'b0;
    bit calm       = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int errors     = 0;
    int idle_count = 0;

    lin_master_frame_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Protected identifier: parity P0 in bit 6, inverted parity P1 in bit 7.
    function automatic logic [7:0] lin_pid(input logic [5:0] id);
        return {~^{id[5], id[4], id[3], id[1]}, ^{id[4], id[2:0]}, id};
    endfunction

    // One step of the enhanced checksum: sums of 256 or more drop by 255.
    function automatic logic [7:0] lin_sum_step(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        if (s >= 9'd256)
            s = s - 9'd255;
        return s[7:0];
    endfunction

    function automatic t_result result_of(input logic [1:0] kind, input logic [7:0] value,
                                          input logic ok);
        t_result r;
        r.kind        = kind;
        r.byte_value  = value;
        r.checksum_ok = ok;
        r.last        = 1'b0;
        return r;
    endfunction

    // Advance the model by one accepted item and queue the results it causes.
    task automatic predict_engine(input t_item it);
        t_result outs[MAX_RESULTS];
        int      n;
        n = 0;
        case (it.action)
            ACT_START_SEND, ACT_START_READ: begin
                link_len   = (it.length > MAX_DATA_BYTES) ? MAX_DATA_BYTES : it.length;
                link_pid   = lin_pid(it.frame_id);
                link_sum   = link_pid;
                link_count = '0;
                link_ticks = '0;
                outs[0] = result_of(KIND_BREAK, 8'h00, 1'b0);
                outs[1] = result_of(KIND_TX_BYTE, SYNC_BYTE, 1'b0);
                outs[2] = result_of(KIND_TX_BYTE, link_pid, 1'b0);
                n = 3;
                if (it.action == ACT_START_READ) begin
                    link_mode = LINK_READ;
                end else if (link_len == 4'd0) begin
                    outs[3] = result_of(KIND_TX_BYTE, ~link_sum, 1'b0);
                    n = 4;
                    link_mode = LINK_IDLE;
                end else begin
                    link_mode = LINK_SEND;
                end
            end
            ACT_DATA_BYTE: begin
                if (link_mode == LINK_SEND) begin
                    outs[0] = result_of(KIND_TX_BYTE, it.data_byte, 1'b0);
                    n = 1;
                    link_sum   = lin_sum_step(link_sum, it.data_byte);
                    link_count = link_count + 4'd1;
                    if (link_count >= link_len) begin
                        outs[1] = result_of(KIND_TX_BYTE, ~link_sum, 1'b0);
                        n = 2;
                        link_mode = LINK_IDLE;
                    end
                end
            end
            ACT_RECV_BYTE: begin
                if (link_mode == LINK_READ) begin
                    if (link_count < link_len) begin
                        outs[0] = result_of(KIND_RX_BYTE, it.data_byte, 1'b0);
                        link_sum   = lin_sum_step(link_sum, it.data_byte);
                        link_count = link_count + 4'd1;
                    end else begin
                        outs[0] = result_of(KIND_READ_DONE, 8'h00,
                                            it.data_byte == ~link_sum);
                        link_mode = LINK_IDLE;
                    end
                    n = 1;
                end
            end
            ACT_TICK: begin
                if (link_mode == LINK_READ) begin
                    if (link_ticks != TICK_MAX)
                        link_ticks = link_ticks + 16'd1;
                    if (link_ticks >= link_timeout) begin
                        outs[0] = result_of(KIND_READ_DONE, 8'h00, 1'b0);
                        n = 1;
                        link_mode = LINK_IDLE;
                    end
                end
            end
            default: ;
        endcase
        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(outs[i]);
    endtask

    // Record each accepted input transfer and predict its results.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            item_taken = 1'b1;
            predict_engine(t_item'(s_axis_tdata[$bits(t_item)-1:0]));
        end
    end

    // Input driver: holds an item until it is taken, with random gaps between items.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || item_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(24 - $bits(t_item)){1'b0}}, pending_items.pop_front()};
                if (!calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 9);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // Result sink: random stall bursts on tready.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 9);
        end
    end

    // Result checker: compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d byte %02h ok %0d last %0d",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
                errors = errors + 1;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    errors = errors + 1;
                end
                if (m_axis_tdata[7:0] !== want.byte_value) begin
                    $error("byte_value: expected %02h, got %02h",
                           want.byte_value, m_axis_tdata[7:0]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[8] !== want.checksum_ok) begin
                    $error("checksum_ok: expected %0d, got %0d",
                           want.checksum_ok, m_axis_tdata[8]);
                    errors = errors + 1;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog: too many cycles with no transfer on either side ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_count = 0;
            else
                idle_count = idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [2:0] action, input logic [5:0] id,
                             input logic [3:0] len, input logic [7:0] b);
        t_item it;
        it.action    = action;
        it.frame_id  = id;
        it.length    = len;
        it.data_byte = b;
        pending_items.push_back(it);
    endtask

    function automatic logic [3:0] pick_length();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    // Well-formed send frame with random content, now and then cut short.
    task automatic gen_send_frame(inout int made);
        logic [3:0] len;
        int         n;
        len = pick_length();
        n = (len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len;
        if (n > 0 && $urandom_range(0, 7) == 0)
            n = $urandom_range(0, n - 1);
        push_item(ACT_START_SEND, 6'($urandom), len, 8'($urandom));
        for (int i = 0; i < n; i++)
            push_item(ACT_DATA_BYTE, 6'($urandom), 4'($urandom), 8'($urandom));
        made = made + 1 + n;
    endtask

    // Read frame: received bytes with stray ticks, then one of several endings.
    task automatic gen_read_frame(inout int made);
        logic [5:0] id;
        logic [3:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        int         ticks;
        id  = 6'($urandom);
        len = pick_length();
        n   = (len > MAX_DATA_BYTES) ? MAX_DATA_BYTES : len;
        sum = lin_pid(id);
        push_item(ACT_START_READ, id, len, 8'($urandom));
        made = made + 1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                push_item(ACT_TICK, 6'($urandom), 4'($urandom), 8'($urandom));
                made = made + 1;
            end
            b = 8'($urandom);
            push_item(ACT_RECV_BYTE, 6'($urandom), 4'($urandom), b);
            sum = lin_sum_step(sum, b);
            made = made + 1;
        end
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                push_item(ACT_RECV_BYTE, 6'($urandom), 4'($urandom), ~sum);
                made = made + 1;
            end
            3: begin
                push_item(ACT_RECV_BYTE, 6'($urandom), 4'($urandom),
                          ~sum ^ 8'($urandom_range(1, 255)));
                made = made + 1;
            end
            4: begin
                ticks = (link_timeout > 16'd20) ? 20 : int'(link_timeout) + 1;
                repeat (ticks)
                    push_item(ACT_TICK, 6'($urandom), 4'($urandom), 8'($urandom));
                made = made + ticks;
            end
            default: ;
        endcase
    endtask

    // Wait until every item is taken and every result has come, then let it drain.
    task automatic settle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        link_timeout = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [15:0] timeout, input int count,
                                    input bit quiet);
        int made;
        made = 0;
        settle();
        write_timeout(timeout);
        calm = quiet;
        while (made < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gen_send_frame(made);
                4, 5, 6, 7: gen_read_frame(made);
                default: begin
                    // Noise: any action code with any field values.
                    repeat ($urandom_range(1, 3))
                        push_item(3'($urandom), 6'($urandom), 4'($urandom), 8'($urandom));
                end
            endcase
        end
    endtask

    // Main sequence: reset, directed frames, then random phases.
    initial begin
        logic [7:0] sum;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_timeout(16'd3);

        // Empty send frame: checksum follows the header at once.
        push_item(ACT_START_SEND, 6'h00, 4'd0, 8'h00);
        // Length above the maximum is clamped; bytes chosen to force wraps.
        push_item(ACT_START_SEND, 6'h3F, 4'd15, 8'hFF);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'hFF);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'hFF);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'hFF);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'h00);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'h80);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'hFF);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'h01);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'hFE);
        // Items that do nothing while idle, and undefined action codes.
        push_item(ACT_DATA_BYTE, 6'h3F, 4'd15, 8'hFF);
        push_item(ACT_RECV_BYTE, 6'h3F, 4'd15, 8'hFF);
        push_item(ACT_TICK, 6'h3F, 4'd15, 8'hFF);
        push_item(3'd5, 6'h3F, 4'd15, 8'hFF);
        push_item(3'd7, 6'h2A, 4'd8, 8'h55);
        // Read with a matching checksum.
        sum = lin_sum_step(lin_sum_step(lin_pid(6'h2A), 8'hFF), 8'h01);
        push_item(ACT_START_READ, 6'h2A, 4'd2, 8'h00);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, 8'hFF);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, 8'h01);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, ~sum);
        // Empty read: the first byte is the checksum, here a wrong one.
        push_item(ACT_START_READ, 6'h15, 4'd0, 8'h00);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, ~lin_pid(6'h15) ^ 8'h01);
        // Read that runs into the timeout.
        push_item(ACT_START_READ, 6'h3C, 4'd8, 8'h00);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, 8'hAA);
        push_item(ACT_TICK, 6'h00, 4'd0, 8'h00);
        push_item(ACT_TICK, 6'h00, 4'd0, 8'h00);
        push_item(ACT_TICK, 6'h00, 4'd0, 8'h00);
        // Start while a send frame is in progress abandons it.
        sum = lin_sum_step(lin_pid(6'h02), 8'h00);
        push_item(ACT_START_SEND, 6'h01, 4'd3, 8'h00);
        push_item(ACT_DATA_BYTE, 6'h00, 4'd0, 8'h10);
        push_item(ACT_START_READ, 6'h02, 4'd1, 8'h00);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, 8'h00);
        push_item(ACT_RECV_BYTE, 6'h00, 4'd0, ~sum);

        run_random_phase(16'd0, 65, 1'b0);
        run_random_phase(16'hFFFF, 85, 1'b0);
        run_random_phase(16'd1, 65, 1'b0);
        run_random_phase(16'($urandom_range(2, 12)), 65, 1'b0);
        run_random_phase(16'($urandom_range(2, 16)), 65, 1'b1);

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
